/* hw/rtl/qalu_pkg.sv */
// Shared types, operation codes and status codes for the Q24.8 fixed-point ALU.
package qalu_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_W        = 32;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_GT    = 4'd4,
		OP_GE    = 4'd5,
		OP_LT    = 4'd6,
		OP_LE    = 4'd7,
		OP_EQ    = 4'd8,
		OP_NE    = 4'd9,
		OP_MIN   = 4'd10,
		OP_MAX   = 4'd11,
		OP_INC   = 4'd12,
		OP_DEC   = 4'd13,
		OP_FROM  = 4'd14,
		OP_TOINT = 4'd15
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// Outcome of the front stage.
	typedef struct packed {
		logic [WORD_W-1:0] res;
		logic              cmp;
		logic [1:0]        st;
		logic              neg;
		logic [WORD_W-1:0] ma;
		logic [WORD_W-1:0] mb;
	} front_t;

endpackage

/* hw/rtl/qalu_front.sv */
// Front stage: short operations, comparisons and operand magnitudes.
module qalu_front import qalu_pkg::*; #(
	parameter int FracBits = FRAC_BITS_DEF
) (
	input  op_t                      operation,
	input  logic signed [WORD_W-1:0] operand_a,
	input  logic signed [WORD_W-1:0] operand_b,
	output front_t                   fr
);

	logic signed [WORD_W:0]     sum;
	logic signed [WORD_W:0]     dif;
	logic signed [WORD_W:0]     incv;
	logic signed [WORD_W:0]     decv;
	logic signed [2*WORD_W-1:0] ax;
	logic signed [2*WORD_W-1:0] sh;
	logic [WORD_W-1:0]          ma;
	logic [WORD_W-1:0]          mb;
	logic [WORD_W-1:0]          ti;
	logic                       gt;
	logic                       eq;

	always_comb begin
		sum  = {operand_a[WORD_W-1], operand_a} + {operand_b[WORD_W-1], operand_b};
		dif  = {operand_a[WORD_W-1], operand_a} - {operand_b[WORD_W-1], operand_b};
		incv = {operand_a[WORD_W-1], operand_a} + (WORD_W+1)'(1);
		decv = {operand_a[WORD_W-1], operand_a} - (WORD_W+1)'(1);
		ax   = (2*WORD_W)'(operand_a);
		sh   = ax <<< FracBits;
		ma   = operand_a[WORD_W-1] ? (~operand_a + 1'b1) : operand_a;
		mb   = operand_b[WORD_W-1] ? (~operand_b + 1'b1) : operand_b;
		ti   = ma >> FracBits;
		gt   = operand_a > operand_b;
		eq   = operand_a == operand_b;

		fr     = '0;
		fr.ma  = ma;
		fr.mb  = mb;
		fr.neg = operand_a[WORD_W-1] ^ operand_b[WORD_W-1];
		unique case (operation)
			OP_ADD: begin
				fr.res = sum[WORD_W-1:0];
				fr.st  = (sum[WORD_W] != sum[WORD_W-1]) ? ST_OVF : ST_OK;
			end
			OP_SUB: begin
				fr.res = dif[WORD_W-1:0];
				fr.st  = (dif[WORD_W] != dif[WORD_W-1]) ? ST_OVF : ST_OK;
			end
			OP_MUL: fr.st = ST_OK;
			OP_DIV: fr.st = (operand_b == '0) ? ST_DIVZ : ST_OK;
			OP_GT:  fr.cmp = gt;
			OP_GE:  fr.cmp = gt | eq;
			OP_LT:  fr.cmp = ~(gt | eq);
			OP_LE:  fr.cmp = ~gt;
			OP_EQ:  fr.cmp = eq;
			OP_NE:  fr.cmp = ~eq;
			OP_MIN: fr.res = (gt | eq) ? operand_b : operand_a;
			OP_MAX: fr.res = gt ? operand_a : operand_b;
			OP_INC: begin
				fr.res = incv[WORD_W-1:0];
				fr.st  = (incv[WORD_W] != incv[WORD_W-1]) ? ST_OVF : ST_OK;
			end
			OP_DEC: begin
				fr.res = decv[WORD_W-1:0];
				fr.st  = (decv[WORD_W] != decv[WORD_W-1]) ? ST_OVF : ST_OK;
			end
			OP_FROM: begin
				fr.res = sh[WORD_W-1:0];
				fr.st  = (sh[2*WORD_W-1:WORD_W] != {WORD_W{sh[WORD_W-1]}}) ? ST_OVF : ST_OK;
			end
			OP_TOINT: fr.res = operand_a[WORD_W-1] ? (~ti + 1'b1) : ti;
			default: fr.res = '0;
		endcase
	end

endmodule

/* hw/rtl/qalu_div_step.sv */
// One restoring-division step: shift in a numerator bit, trial subtract.
module qalu_div_step import qalu_pkg::*; #(
	parameter int QW = WORD_W + FRAC_BITS_DEF
) (
	input  logic [WORD_W-1:0] rem_i,
	input  logic [QW-1:0]     num_i,
	input  logic [QW-1:0]     quo_i,
	input  logic [WORD_W-1:0] den,
	output logic [WORD_W-1:0] rem_o,
	output logic [QW-1:0]     num_o,
	output logic [QW-1:0]     quo_o
);

	logic [WORD_W:0] t;
	logic [WORD_W:0] d;
	logic            ge;

	always_comb begin
		t     = {rem_i, num_i[QW-1]};
		d     = {1'b0, den};
		ge    = t >= d;
		rem_o = ge ? WORD_W'(t - d) : t[WORD_W-1:0];
		num_o = {num_i[QW-2:0], 1'b0};
		quo_o = {quo_i[QW-2:0], ge};
	end

endmodule

/* hw/rtl/fixed_point_q24_8_alu_top.sv */
// Top level of the pipelined signed fixed-point ALU.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | operation, operand_a, operand_b
//  output  | out_valid / out_ready| result_word, compare_true, status
//
// One transfer per cycle in each direction when neither side stalls.
// The pipe is one front stage, one restoring-divider stage per quotient bit
// (32 + FracBits of them), then a rounding stage and a sign/overflow stage
// that is the output register.
// Every operation walks the full pipe so results leave in order.
// Reset clears all stage valid bits; the datapath registers are not reset.
// Each stage holds while it is full and the one after it holds; empty stages
// advance regardless, so bubbles squeeze out behind a stalled output.
module fixed_point_q24_8_alu_top import qalu_pkg::*; #(
	parameter int FracBits = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               operation,
	input  logic signed [WORD_W-1:0] operand_a,
	input  logic signed [WORD_W-1:0] operand_b,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [WORD_W-1:0] result_word,
	output logic                     compare_true,
	output logic [1:0]               status
);

	localparam int QW = WORD_W + FracBits;  // quotient bits
	localparam int NS = QW + 3;             // pipeline depth

	typedef struct packed {
		op_t               op;
		logic [WORD_W-1:0] res;
		logic              cmp;
		logic [1:0]        st;
		logic              neg;
		logic [63:0]       prod;  // product, later the rounded magnitude
		logic [WORD_W-1:0] rem;
		logic [QW-1:0]     num;
		logic [QW-1:0]     quo;
		logic [WORD_W-1:0] den;
	} stage_t;

	stage_t pl_s [NS];
	stage_t nxt  [NS];
	logic   vld_s[NS];
	logic   en   [NS];
	front_t fr;

	// Enable chain: a stage may load when empty or when its successor loads.
	always_comb begin
		en[NS-1] = ~vld_s[NS-1] | out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = ~vld_s[k] | en[k+1];
		end
	end

	assign in_ready = en[0];

	qalu_front #(.FracBits(FracBits)) u_front (
		.operation(op_t'(operation)),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.fr       (fr)
	);

	// Front stage: short ops finish here; load the divider with |a| << F.
	always_comb begin
		nxt[0]      = '0;
		nxt[0].op   = op_t'(operation);
		nxt[0].res  = fr.res;
		nxt[0].cmp  = fr.cmp;
		nxt[0].st   = fr.st;
		nxt[0].neg  = fr.neg;
		nxt[0].num  = QW'(fr.ma) << FracBits;
		nxt[0].den  = fr.mb;
	end

	// Divider stages, one quotient bit each; the first also forms the product.
	for (genvar k = 1; k <= QW; k++) begin : g_div
		logic [WORD_W-1:0] rem_n;
		logic [QW-1:0]     num_n;
		logic [QW-1:0]     quo_n;

		qalu_div_step #(.QW(QW)) u_step (
			.rem_i(pl_s[k-1].rem),
			.num_i(pl_s[k-1].num),
			.quo_i(pl_s[k-1].quo),
			.den  (pl_s[k-1].den),
			.rem_o(rem_n),
			.num_o(num_n),
			.quo_o(quo_n)
		);

		always_comb begin
			nxt[k]     = pl_s[k-1];
			nxt[k].rem = rem_n;
			nxt[k].num = num_n;
			nxt[k].quo = quo_n;
			if (k == 1) begin
				nxt[k].prod = 64'(pl_s[k-1].num[QW-1:FracBits]) * 64'(pl_s[k-1].den);
			end
		end
	end

	// Rounding stage: half away from zero on the magnitudes.
	always_comb begin
		logic [WORD_W:0] r2;
		logic            up;
		r2          = {pl_s[QW].rem, 1'b0};
		up          = r2 >= {1'b0, pl_s[QW].den};
		nxt[QW+1]   = pl_s[QW];
		if (pl_s[QW].op == OP_MUL) begin
			nxt[QW+1].prod = (pl_s[QW].prod + (64'(1) << (FracBits - 1))) >> FracBits;
		end else begin
			nxt[QW+1].prod = 64'(pl_s[QW].quo) + 64'(up);
		end
	end

	// Sign and overflow stage for multiply and divide.
	always_comb begin
		logic [63:0] m;
		logic [63:0] sv;
		logic        ovf;
		m         = pl_s[QW+1].prod;
		sv        = pl_s[QW+1].neg ? (~m + 64'(1)) : m;
		ovf       = (m[63:WORD_W-1] != '0) &&
		            !(pl_s[QW+1].neg && m == (64'(1) << (WORD_W - 1)));
		nxt[QW+2] = pl_s[QW+1];
		if (pl_s[QW+1].op == OP_MUL ||
		    (pl_s[QW+1].op == OP_DIV && pl_s[QW+1].st != ST_DIVZ)) begin
			nxt[QW+2].res = sv[WORD_W-1:0];
			nxt[QW+2].st  = ovf ? ST_OVF : ST_OK;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= (k == 0) ? in_valid : vld_s[(k == 0) ? 0 : k - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				pl_s[k] <= nxt[k];
			end
		end
	end

	assign out_valid    = vld_s[NS-1];
	assign result_word  = pl_s[NS-1].res;
	assign compare_true = pl_s[NS-1].cmp;
	assign status       = pl_s[NS-1].st;

endmodule

/* hw/rtl/qalu_chk.sv */
// Port-level checker for the fixed-point ALU, with its bind.
module qalu_chk import qalu_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] result_word,
	input logic              compare_true,
	input logic [1:0]        status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_word) && $stable(status))
		else $error("output changed while stalled");

	a_divz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DIVZ |-> result_word == '0 && !compare_true)
		else $error("divide by zero result not clean");

	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> result_word == '0 && status == ST_OK)
		else $error("comparison result carries data");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ST_OK || status == ST_DIVZ || status == ST_OVF)
		else $error("undefined status code");

endmodule

bind fixed_point_q24_8_alu_top qalu_chk u_qalu_chk (.*);

/* sim/fixed_point_q24_8_alu_top_tb.sv */
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
`timescale 1ns / 100ps

module fixed_point_q24_8_alu_top_tb;
	import qalu_pkg::*;

	localparam int FRAC      = FRAC_BITS_DEF;
	localparam int LATENCY   = FRAC + 35;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 1500;

	typedef struct {
		op_t                 op;
		logic signed [31:0]  a;
		logic signed [31:0]  b;
	} alu_req_t;

	typedef struct {
		logic signed [31:0] word;
		logic               cmp;
		logic [1:0]         st;
	} alu_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] operation = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] result_word;
	logic compare_true;
	logic [1:0] status;

	alu_req_t pending_reqs[$];
	alu_res_t expected_results[$];
	int  send_idle_pct = 36;
	int  recv_idle_pct = 80;
	bit  hold_sender   = 1'b0;
	int  n_errors      = 0;
	int  n_checked     = 0;
	int  n_sent        = 0;
	int  idle_cycles   = 0;

	fixed_point_q24_8_alu_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_word(result_word), .compare_true(compare_true), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Wrap a wide value to 32 bits, flagging overflow.
	function automatic void fit_word(input logic signed [127:0] v,
			ref logic signed [31:0] w, ref logic [1:0] st);
		w = v[31:0];
		if (v > 128'sd2147483647 || v < -128'sd2147483648)
			st = ST_OVF;
	endfunction

	// Compute the expected ALU outcome for one request.
	function automatic alu_res_t alu_predict(alu_req_t r);
		alu_res_t res;
		logic signed [127:0] a, b, p, m;
		logic [127:0] na, nb, q;
		logic neg;
		a = r.a;
		b = r.b;
		res.word = '0;
		res.cmp  = 1'b0;
		res.st   = ST_OK;
		case (r.op)
			OP_ADD: fit_word(a + b, res.word, res.st);
			OP_SUB: fit_word(a - b, res.word, res.st);
			OP_MUL: begin
				p = a * b;
				na = (p < 0) ? -p : p;
				q = (na + (128'd1 << (FRAC - 1))) >> FRAC;
				m = q;
				fit_word((p < 0) ? -m : m, res.word, res.st);
			end
			OP_DIV: begin
				if (b == 0) begin
					res.st = ST_DIVZ;
				end else begin
					na = ((a < 0) ? -a : a) << FRAC;
					nb = (b < 0) ? -b : b;
					q = (2 * na + nb) / (2 * nb);
					m = q;
					neg = (a < 0) != (b < 0);
					fit_word(neg ? -m : m, res.word, res.st);
				end
			end
			OP_GT:  res.cmp = a > b;
			OP_GE:  res.cmp = a >= b;
			OP_LT:  res.cmp = a < b;
			OP_LE:  res.cmp = a <= b;
			OP_EQ:  res.cmp = a == b;
			OP_NE:  res.cmp = a != b;
			OP_MIN: res.word = (a >= b) ? r.b : r.a;
			OP_MAX: res.word = (a <= b) ? r.b : r.a;
			OP_INC: fit_word(a + 1, res.word, res.st);
			OP_DEC: fit_word(a - 1, res.word, res.st);
			OP_FROM: fit_word(a <<< FRAC, res.word, res.st);
			default: begin
				na = (a < 0) ? -a : a;
				m = na >> FRAC;
				res.word = 32'((a < 0) ? -m : m);
			end
		endcase
		return res;
	endfunction

	// Bias operands toward edges, small values and whole fixed-point numbers.
	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000 + $urandom_range(0, 3);
			1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
			2: return $signed($urandom_range(0, 8191)) - 4096;
			3: return ($signed($urandom_range(0, 255)) - 128) <<< FRAC;
			4: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_req(op_t op, logic signed [31:0] a, logic signed [31:0] b);
		alu_req_t r;
		r.op = op;
		r.a  = a;
		r.b  = b;
		pending_reqs.push_back(r);
	endtask

	// Driver: present the next pending request, hold it until its transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				expected_results.push_back(alu_predict('{op_t'(operation),
					operand_a, operand_b}));
				n_sent++;
			end
			if (pending_reqs.size() != 0 && !hold_sender &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				alu_req_t r;
				r = pending_reqs.pop_front();
				in_valid  <= 1'b1;
				operation <= r.op;
				operand_a <= r.a;
				operand_b <= r.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each result transfer with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: word %0d", result_word);
					n_errors++;
				end else begin
					alu_res_t e;
					e = expected_results.pop_front();
					if (result_word !== e.word) begin
						$error("result_word: expected %0d, got %0d", e.word, result_word);
						n_errors++;
					end
					if (compare_true !== e.cmp) begin
						$error("compare_true: expected %0b, got %0b", e.cmp, compare_true);
						n_errors++;
					end
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						n_errors++;
					end
					n_checked++;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int k;
		logic signed [31:0] ext[6];
		op_t o;
		ext = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1, -1, 32'sh0000_0100};

		// Directed: each operation on extremes, divide by zero, rounding ties.
		for (int i = 0; i < 16; i++)
			queue_req(op_t'(i), ext[i % 6], ext[(i + 1) % 6]);
		queue_req(OP_DIV, 32'sh0000_0500, 0);
		queue_req(OP_DIV, 32'sh8000_0000, 1);
		queue_req(OP_MUL, 32'sh0000_0180, 32'sh0000_0001);
		queue_req(OP_MUL, -32'sh0000_0180, 32'sh0000_0001);
		queue_req(OP_DIV, 1, 2);
		queue_req(OP_DIV, -1, 2);
		queue_req(OP_INC, 32'sh7FFF_FFFF, 0);
		queue_req(OP_DEC, 32'sh8000_0000, 0);
		queue_req(OP_TOINT, -32'sh0000_0101, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < N_RANDOM; k++) begin
			o = op_t'($urandom_range(0, 15));
			queue_req(o, pick_operand(), pick_operand());
			if (k == N_RANDOM / 3) begin
				// Let the pipe drain completely before sending more.
				wait (pending_reqs.size() == 0 && !in_valid);
				hold_sender = 1'b1;
				wait (expected_results.size() == 0);
				hold_sender = 1'b0;
				send_idle_pct = 80;
				recv_idle_pct = 36;
			end else if (k == 2 * N_RANDOM / 3) begin
				wait (pending_reqs.size() == 0 && !in_valid);
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		end

		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d requests over all sixteen operations, checked %0d results,",
			n_sent, n_checked);
		$display("under three sender/receiver stall mixes with one full drain.");
		if (n_errors == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
